// File: hdl/dtse_pkg.sv
// ----------------------------------------------------------------------------
// dtse_pkg: shared types, constants and wrap helpers
// Field types, cursor position codes and the small modulo and calendar
// functions used by the date/time setting editor.
// ----------------------------------------------------------------------------
`default_nettype none

package dtse_pkg;

  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  day_t;
  typedef logic [2:0]  wday_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minute_t;
  typedef logic [3:0]  pos_t;

  // pending change, two's complement +1 / -1
  typedef enum logic [1:0] {
    PEND_NONE = 2'b00,
    PEND_UP   = 2'b01,
    PEND_DOWN = 2'b11
  } pend_t;

  // cursor positions
  localparam pos_t POS_Y1000   = 4'd0;
  localparam pos_t POS_Y100    = 4'd1;
  localparam pos_t POS_Y10     = 4'd2;
  localparam pos_t POS_Y1      = 4'd3;
  localparam pos_t POS_MON10   = 4'd4;
  localparam pos_t POS_MON1    = 4'd5;
  localparam pos_t POS_DAY10   = 4'd6;
  localparam pos_t POS_DAY1    = 4'd7;
  localparam pos_t POS_WDAY    = 4'd8;
  localparam pos_t POS_HOUR10  = 4'd9;
  localparam pos_t POS_HOUR1   = 4'd10;
  localparam pos_t POS_MIN10   = 4'd11;
  localparam pos_t POS_MIN1    = 4'd12;
  localparam pos_t POS_SET     = 4'd13;

  localparam logic [5:0] WEEK_LEN   = 6'd7;
  localparam logic [5:0] DAY_HOURS  = 6'd24;
  localparam logic [5:0] HOUR_MINS  = 6'd60;
  localparam logic [5:0] YEAR_MONS  = 6'd12;
  localparam logic [3:0] MONTH_FEB  = 4'd2;

  // word carried by the result channel
  typedef struct packed {
    year_t   year;
    month_t  month;
    day_t    day;
    wday_t   weekday;
    hour_t   hour;
    minute_t minute;
    pos_t    cursor;
    logic    exiting;
    logic    save;
  } out_word_t;

  // Value plus or minus one digit weight, small fields only.
  function automatic logic signed [7:0] step_small(logic [5:0] v, pend_t p, logic [3:0] w);
    logic signed [7:0] vs;
    logic signed [7:0] ws;
    logic signed [7:0] r;
    vs = $signed({2'b00, v});
    ws = $signed({4'b0000, w});
    unique case (p)
      PEND_UP:   r = vs + ws;
      PEND_DOWN: r = vs - ws;
      default:   r = vs;
    endcase
    return r;
  endfunction

  // True modulo for v in [-m, 3m), m up to 63.
  function automatic logic [5:0] wrap_small(logic signed [7:0] v, logic [5:0] m);
    logic signed [8:0] vs;
    logic signed [8:0] ms;
    logic signed [8:0] r;
    vs = {v[7], v};
    ms = $signed({3'b000, m});
    priority if (vs < 9'sd0)   r = vs + ms;
    else if (vs >= ms + ms)    r = vs - ms - ms;
    else if (vs >= ms)         r = vs - ms;
    else                       r = vs;
    return r[5:0];
  endfunction

  // Gregorian leap rule. Divisibility by 25 is checked on y/4 split as
  // 32a+b, since 32 = 7 mod 25 the residue class of 7a+b (at most 248) decides.
  function automatic logic is_leap(year_t y);
    logic [4:0] a;
    logic [4:0] b;
    logic [7:0] s;
    logic       m25;
    a   = y[11:7];
    b   = y[6:2];
    s   = ({a, 3'b000} - {3'b000, a}) + {3'b000, b};
    m25 = 1'b0;
    for (int i = 0; i < 10; i++) begin
      if (s == 8'(25 * i)) m25 = 1'b1;
    end
    return (y[1:0] == 2'b00) && (!m25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [5:0] month_len(month_t m, logic leap);
    logic [5:0] len;
    unique case (m)
      4'd2:                      len = leap ? 6'd29 : 6'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 6'd30;
      default:                   len = 6'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// File: hdl/dtse_in_if.sv
// ----------------------------------------------------------------------------
// dtse_in_if: button scan channel
// Valid/ready channel carrying one scan of the buttons and optional load.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtse_in_if import dtse_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    up_pressed;
  logic    down_pressed;
  logic    next_pressed;
  logic    back_pressed;
  logic    load;
  year_t   load_year;
  month_t  load_month;
  day_t    load_day;
  wday_t   load_weekday;
  hour_t   load_hour;
  minute_t load_minute;

  modport source (
    output valid, up_pressed, down_pressed, next_pressed, back_pressed, load,
           load_year, load_month, load_day, load_weekday, load_hour, load_minute,
    input  ready
  );

  modport sink (
    input  valid, up_pressed, down_pressed, next_pressed, back_pressed, load,
           load_year, load_month, load_day, load_weekday, load_hour, load_minute,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/dtse_out_if.sv
// ----------------------------------------------------------------------------
// dtse_out_if: editor result channel
// Valid/ready channel carrying the edited values, cursor and exit flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtse_out_if import dtse_pkg::*; ();
  logic    valid;
  logic    ready;
  year_t   year;
  month_t  month;
  day_t    day;
  wday_t   weekday;
  hour_t   hour;
  minute_t minute;
  pos_t    cursor;
  logic    exiting;
  logic    save;

  modport source (
    output valid, year, month, day, weekday, hour, minute, cursor, exiting, save,
    input  ready
  );

  modport sink (
    input  valid, year, month, day, weekday, hour, minute, cursor, exiting, save,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/date_time_setting_editor.sv
// ----------------------------------------------------------------------------
// date_time_setting_editor: button-driven date and time set mode
// Holds the edited date/time, the cursor and the pending change, and returns
// one result word per button scan.
// ----------------------------------------------------------------------------
// Each scan word is processed combinationally: the load, the button decode, the
// digit step and the wrap of every field are one pass of logic between the
// state registers and the result register, so a new scan is taken every
// cycle while the result register is empty or being drained. The result
// appears the cycle after the scan is taken. A scan with load set (re)starts
// a session at cursor 0; next at the set position exits with save, back at
// position 0 exits without it. Scans outside a session return the stored
// values unchanged.
`default_nettype none

module date_time_setting_editor import dtse_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  dtse_in_if.sink    in_chan,
  dtse_out_if.source out_chan
);

  year_t     year_r,   year_nxt;
  month_t    month_r,  month_nxt;
  day_t      day_r,    day_nxt;
  wday_t     wday_r,   wday_nxt;
  hour_t     hour_r,   hour_nxt;
  minute_t   minute_r, minute_nxt;
  pos_t      cursor_r, cursor_nxt;
  pend_t     pend_r,   pend_nxt;
  logic      active_r, active_nxt;
  logic      out_valid_r;
  out_word_t out_r,    out_nxt;

  logic    in_fire;
  logic    act;
  year_t   year0, year1;
  month_t  month0;
  day_t    day0;
  wday_t   wday0;
  hour_t   hour0;
  minute_t minute0;
  pos_t    c0, c1, c2;
  pend_t   pend1;
  logic    ex_next, ex_back, exiting, leap;
  logic [11:0] yw;
  logic [3:0]  mw, dw, ww, hw, nw;
  logic [5:0]  mon_m1, dlen, day_m1;
  month_t      month1;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  always_comb begin
    year0   = in_chan.load ? in_chan.load_year    : year_r;
    month0  = in_chan.load ? in_chan.load_month   : month_r;
    day0    = in_chan.load ? in_chan.load_day     : day_r;
    wday0   = in_chan.load ? in_chan.load_weekday : wday_r;
    hour0   = in_chan.load ? in_chan.load_hour    : hour_r;
    minute0 = in_chan.load ? in_chan.load_minute  : minute_r;
    c0      = in_chan.load ? POS_Y1000            : cursor_r;
    act     = in_chan.load || active_r;

    pend1 = pend_r;
    if (in_chan.up_pressed)   pend1 = PEND_UP;
    if (in_chan.down_pressed) pend1 = PEND_DOWN;

    // next acts before back
    ex_next = in_chan.next_pressed && (c0 == POS_SET);
    c1      = (in_chan.next_pressed && !ex_next) ? c0 + 4'd1 : c0;
    ex_back = in_chan.back_pressed && (c1 == POS_Y1000);
    c2      = (in_chan.back_pressed && !ex_back) ? c1 - 4'd1 : c1;
    exiting = ex_next || ex_back;

    yw = '0; mw = '0; dw = '0; ww = '0; hw = '0; nw = '0;
    unique case (c2)
      POS_Y1000:  yw = 12'd1000;
      POS_Y100:   yw = 12'd100;
      POS_Y10:    yw = 12'd10;
      POS_Y1:     yw = 12'd1;
      POS_MON10:  mw = 4'd10;
      POS_MON1:   mw = 4'd1;
      POS_DAY10:  dw = 4'd10;
      POS_DAY1:   dw = 4'd1;
      POS_WDAY:   ww = 4'd1;
      POS_HOUR10: hw = 4'd10;
      POS_HOUR1:  hw = 4'd1;
      POS_MIN10:  nw = 4'd10;
      POS_MIN1:   nw = 4'd1;
      default: ;
    endcase

    // year wraps modulo 4096 by plain 12-bit arithmetic
    unique case (pend1)
      PEND_UP:   year1 = year0 + yw;
      PEND_DOWN: year1 = year0 - yw;
      default:   year1 = year0;
    endcase

    mon_m1 = wrap_small(step_small({2'b00, month0}, pend1, mw) - 8'sd1, YEAR_MONS);
    month1 = 4'(mon_m1 + 6'd1);
    leap   = is_leap(year1);
    dlen   = month_len(month1, leap);
    day_m1 = wrap_small(step_small({1'b0, day0}, pend1, dw) - 8'sd1, dlen);

    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    wday_nxt   = wday_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    cursor_nxt = cursor_r;
    pend_nxt   = pend_r;
    active_nxt = active_r;
    if (act) begin
      year_nxt   = year1;
      month_nxt  = month1;
      day_nxt    = 5'(day_m1 + 6'd1);
      wday_nxt   = 3'(wrap_small(step_small({3'b000, wday0}, pend1, ww), WEEK_LEN));
      hour_nxt   = 5'(wrap_small(step_small({1'b0, hour0}, pend1, hw), DAY_HOURS));
      minute_nxt = wrap_small(step_small(minute0, pend1, nw), HOUR_MINS);
      cursor_nxt = c2;
      // a change at the set position stays pending
      pend_nxt   = (c2 == POS_SET) ? pend1 : PEND_NONE;
      active_nxt = !exiting;
    end

    out_nxt.year    = year_nxt;
    out_nxt.month   = month_nxt;
    out_nxt.day     = day_nxt;
    out_nxt.weekday = wday_nxt;
    out_nxt.hour    = hour_nxt;
    out_nxt.minute  = minute_nxt;
    out_nxt.cursor  = cursor_nxt;
    out_nxt.exiting = act && exiting;
    out_nxt.save    = act && ex_next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r      <= '0;
      month_r     <= 4'd1;
      day_r       <= 5'd1;
      wday_r      <= '0;
      hour_r      <= '0;
      minute_r    <= '0;
      cursor_r    <= POS_Y1000;
      pend_r      <= PEND_NONE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        year_r   <= year_nxt;
        month_r  <= month_nxt;
        day_r    <= day_nxt;
        wday_r   <= wday_nxt;
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
        cursor_r <= cursor_nxt;
        pend_r   <= pend_nxt;
        active_r <= active_nxt;
      end
      if (in_fire)             out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) out_r <= out_nxt;
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.year    = out_r.year;
  assign out_chan.month   = out_r.month;
  assign out_chan.day     = out_r.day;
  assign out_chan.weekday = out_r.weekday;
  assign out_chan.hour    = out_r.hour;
  assign out_chan.minute  = out_r.minute;
  assign out_chan.cursor  = out_r.cursor;
  assign out_chan.exiting = out_r.exiting;
  assign out_chan.save    = out_r.save;

endmodule

`default_nettype wire

// File: hdl/dtse_checker.sv
// ----------------------------------------------------------------------------
// dtse_checker: port-level checks for the date/time setting editor
// Watches the scan and result channels and flags missing or illegal result words.
// ----------------------------------------------------------------------------
`default_nettype none

module dtse_checker import dtse_pkg::*; (
  input wire          clk,
  input wire          rst_n,
  input wire          in_valid,
  input wire          in_ready,
  input wire          out_valid,
  input wire          out_ready,
  input wire month_t  out_month,
  input wire day_t    out_day,
  input wire pos_t    out_cursor,
  input wire          out_exiting,
  input wire          out_save
);

  // a taken scan always shows up on the next cycle
  a_scan_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("scan taken but no result word next cycle");

  a_save_needs_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_save |-> out_exiting)
    else $error("save flagged without exit");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor <= POS_SET && out_month >= 4'd1 && out_month <= 4'd12
                  && out_day != 5'd0)
    else $error("result field out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor) && $stable(out_day))
    else $error("stalled result word changed");

endmodule

bind date_time_setting_editor dtse_checker u_dtse_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_month   (out_chan.month),
  .out_day     (out_chan.day),
  .out_cursor  (out_chan.cursor),
  .out_exiting (out_chan.exiting),
  .out_save    (out_chan.save)
);

`default_nettype wire
